@@ design/rfp_pkg.sv @@
package rfp_pkg;
   localparam int SMALL_SLOTS_DEF = 10;
   localparam int SMALL_BYTES_DEF = 3;
   localparam int LARGE_SLOTS_DEF = 2;
   localparam int LARGE_BYTES_DEF = 128;
   localparam int STAGE_DEPTH = 128;
   localparam logic [7:0] DEST_MODE_MASK = 8'h0C;
   localparam logic [7:0] SRC_MODE_MASK = 8'hC0;
   localparam logic [7:0] AGE_RESET = 8'd3;

   localparam logic [2:0] OP_BYTE = 3'd0;
   localparam logic [2:0] OP_FIND_TYPE = 3'd1;
   localparam logic [2:0] OP_FIND_ANY = 3'd2;
   localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
   localparam logic [2:0] OP_CLEAR_OLD = 3'd4;
   localparam logic [2:0] OP_READ = 3'd5;
   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] frame_byte;
      logic       frame_end;
      logic [7:0] energy_level;
      logic       consumed;
      logic [7:0] wanted_type;
      logic [3:0] slot_index;
      logic [6:0] byte_index;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  slot;
      logic [6:0]  payload_length;
      logic [7:0]  frame_seq;
      logic        dst_present;
      logic [15:0] dst_short;
      logic        src_present;
      logic [15:0] src_short;
      logic [7:0]  slot_energy;
      logic [15:0] check_word;
      logic [7:0]  arrival_seq;
      logic [7:0]  data_byte;
   } rsp_type;
endpackage

@@ design/rfp_if.sv @@
interface rfp_req_if import rfp_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rfp_rsp_if import rfp_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rfp_csr_if ();
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/rx_frame_parse_and_slot_store.sv @@
// A frame byte is staged on accept; the frame end byte then parses the header, fetches
// the check word, searches for a free slot passing over occupied ones, copies the payload.
// Find any and clear walk one slot per cycle; find type reads the first payload byte of
// each occupied slot; read byte reads the payload memory before the result is registered.
// Throughput: one transaction at a time; the next is taken once idle with no result held.
// Reset: synchronous, active high; all slots free, counters zero, age_limit 3.
module rx_frame_parse_and_slot_store import rfp_pkg::*; #(
   parameter int SMALL_SLOTS = SMALL_SLOTS_DEF,
   parameter int SMALL_BYTES = SMALL_BYTES_DEF,
   parameter int LARGE_SLOTS = LARGE_SLOTS_DEF,
   parameter int LARGE_BYTES = LARGE_BYTES_DEF
) (
   input logic clock,
   input logic reset,
   rfp_req_if.sink   req,
   rfp_rsp_if.source rsp,
   rfp_csr_if.sink   csr
);
   localparam int TOTAL = SMALL_SLOTS + LARGE_SLOTS;
   localparam int SW = $clog2(TOTAL + 1);
   localparam int SBW = $clog2(SMALL_SLOTS * SMALL_BYTES);
   localparam int LBW = $clog2(LARGE_SLOTS * LARGE_BYTES);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_HDR = 4'd1;
   localparam logic [3:0] ST_PARSE = 4'd2;
   localparam logic [3:0] ST_SRCH = 4'd3;
   localparam logic [3:0] ST_COPY = 4'd4;
   localparam logic [3:0] ST_FIND = 4'd5;
   localparam logic [3:0] ST_FWAIT = 4'd6;
   localparam logic [3:0] ST_CLEAR = 4'd7;
   localparam logic [3:0] ST_RWAIT = 4'd8;
   localparam logic [3:0] ST_RSP = 4'd9;
   localparam logic [3:0] ST_RDATA = 4'd10;

   logic [3:0] state_ff;
   logic [7:0] age_ff;
   logic [7:0] stg_mem [STAGE_DEPTH];
   logic [7:0] count_ff;
   logic [7:0] arrival_ff;
   logic any_ff;
   logic [6:0] len_ff [TOTAL];
   logic [7:0] seq_ff [TOTAL], energy_ff [TOTAL], stamp_ff [TOTAL];
   logic hd_ff [TOTAL], hs_ff [TOTAL];
   logic [15:0] dst_ff [TOTAL], src_ff [TOTAL], chk_ff [TOTAL];
   logic [7:0] small_mem [SMALL_SLOTS * SMALL_BYTES];
   logic [7:0] large_mem [LARGE_SLOTS * LARGE_BYTES];
   // first header bytes of the frame, indices 0..10
   logic [7:0] hbx_ff [11];

   req_type rq_ff;
   rsp_type out_ff;
   logic out_v_ff;
   logic [SW-1:0] idx_ff;
   logic [7:0] ptr_ff;
   logic [7:0] n_ff;
   logic [7:0] pos_ff, plen_ff;
   logic [15:0] pchk_ff;
   logic [2:0] phase_ff;
   logic [7:0] cp_ff;
   logic [SW-1:0] tgt_ff;
   logic [7:0] srd_ff;
   logic [SBW-1:0] sw_addr;
   logic [LBW-1:0] lw_addr;
   logic [SBW-1:0] sr_addr;
   logic [LBW-1:0] lr_addr;
   logic [7:0] sdat_ff, ldat_ff;
   logic cur_small_ff;

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.data = out_ff;

   logic acc;
   assign acc = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= AGE_RESET;
      end else if (csr.valid) begin
         age_ff <= csr.data;
      end
   end

   // staging memory: written on accept, read by ptr
   always_ff @(posedge clock) begin
      if (acc && req.data.operation == OP_BYTE && count_ff < 8'(STAGE_DEPTH)) begin
         stg_mem[count_ff[6:0]] <= req.data.frame_byte;
      end
      srd_ff <= stg_mem[ptr_ff[6:0]];
   end

   // slot helpers
   function automatic rsp_type slot_rsp(input logic [SW-1:0] s, input logic [6:0] l,
                                        input logic [7:0] sq, input logic h1,
                                        input logic [15:0] d, input logic h2,
                                        input logic [15:0] sr, input logic [7:0] e,
                                        input logic [15:0] c, input logic [7:0] a,
                                        input logic [7:0] db);
      rsp_type r;
      r.found = 1'b1;
      r.slot = 4'(s);
      r.payload_length = l;
      r.frame_seq = sq;
      r.dst_present = h1;
      r.dst_short = h1 ? d : 16'd0;
      r.src_present = h2;
      r.src_short = h2 ? sr : 16'd0;
      r.slot_energy = e;
      r.check_word = c;
      r.arrival_seq = a;
      r.data_byte = db;
      return r;
   endfunction

   logic [SW-1:0] idx_n;
   assign idx_n = idx_ff + 1'b1;
   logic idx_small;
   assign idx_small = idx_ff < SW'(SMALL_SLOTS);

   // payload memory read address (slot idx byte bi)
   logic [6:0] rd_bi;
   assign rd_bi = (state_ff == ST_FIND) ? 7'd0 : rq_ff.byte_index;
   always_comb begin
      sr_addr = '0;
      lr_addr = '0;
      if (idx_small) begin
         sr_addr = SBW'(32'(idx_ff) * SMALL_BYTES + 32'(rd_bi));
      end else begin
         lr_addr = LBW'((32'(idx_ff) - SMALL_SLOTS) * LARGE_BYTES + 32'(rd_bi));
      end
   end

   logic copy_we;
   assign copy_we = (state_ff == ST_COPY) && phase_ff == 3'd1;
   always_comb begin
      sw_addr = SBW'(32'(tgt_ff) * SMALL_BYTES + 32'(cp_ff));
      lw_addr = LBW'((32'(tgt_ff) - SMALL_SLOTS) * LARGE_BYTES + 32'(cp_ff));
   end

   always_ff @(posedge clock) begin
      if (copy_we && cur_small_ff) small_mem[sw_addr] <= srd_ff;
      if (copy_we && !cur_small_ff) large_mem[lw_addr] <= srd_ff;
      sdat_ff <= small_mem[sr_addr];
      ldat_ff <= large_mem[lr_addr];
   end

   logic [7:0] rd_data;
   logic rd_in_range;
   always_comb begin
      rd_data = cur_small_ff ? sdat_ff : ldat_ff;
      if (cur_small_ff) rd_in_range = (32'(rd_bi) < SMALL_BYTES);
      else rd_in_range = (32'(rd_bi) < LARGE_BYTES);
   end

   // header parse from captured first bytes
   logic [7:0] pos_c;
   logic ok_c;
   always_comb begin
      pos_c = 8'd3;
      ok_c = n_ff >= 8'd3;
      if ((hbx_ff[1] & DEST_MODE_MASK) != 8'd0) begin
         if (pos_c + 8'd4 > n_ff) ok_c = 1'b0;
         pos_c = pos_c + 8'd4;
      end
      if ((hbx_ff[1] & SRC_MODE_MASK) != 8'd0) begin
         if (pos_c + 8'd4 > n_ff) ok_c = 1'b0;
         pos_c = pos_c + 8'd4;
      end
      if ({1'b0, n_ff} < {1'b0, pos_c} + 9'd2) ok_c = 1'b0;
   end

   logic [15:0] dst_p, src_p;
   always_comb begin
      dst_p = {hbx_ff[6], hbx_ff[5]};
      if ((hbx_ff[1] & DEST_MODE_MASK) != 8'd0) src_p = {hbx_ff[10], hbx_ff[9]};
      else src_p = {hbx_ff[6], hbx_ff[5]};
   end

   logic [7:0] age_c;
   assign age_c = arrival_ff - stamp_ff[idx_ff];

   logic [7:0] rd_byte;
   assign rd_byte = (rq_ff.byte_index < len_ff[idx_ff] && rd_in_range) ? rd_data : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         arrival_ff <= '0;
         any_ff <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < TOTAL; i++) len_ff[i] <= '0;
      end else begin
         if (rsp.valid && rsp.ready) out_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  rq_ff <= req.data;
                  unique case (req.data.operation)
                     OP_BYTE: begin
                        if (count_ff < 8'(STAGE_DEPTH)) begin
                           if (count_ff < 8'd11) hbx_ff[count_ff[3:0]] <= req.data.frame_byte;
                           count_ff <= count_ff + 8'd1;
                        end
                        if (req.data.frame_end) begin
                           n_ff <= (count_ff < 8'(STAGE_DEPTH)) ? count_ff + 8'd1 : count_ff;
                           state_ff <= ST_HDR;
                        end
                     end
                     OP_FIND_TYPE, OP_FIND_ANY: begin
                        idx_ff <= '0;
                        if (any_ff) state_ff <= ST_FIND;
                        else begin
                           out_ff <= '0;
                           out_v_ff <= 1'b1;
                        end
                     end
                     OP_CLEAR_ALL, OP_CLEAR_OLD: begin
                        idx_ff <= '0;
                        if (any_ff) state_ff <= ST_CLEAR;
                     end
                     OP_READ: begin
                        if (32'(req.data.slot_index) < TOTAL &&
                            len_ff[SW'(req.data.slot_index)] != 7'd0) begin
                           idx_ff <= SW'(req.data.slot_index);
                           state_ff <= ST_RWAIT;
                        end else begin
                           out_ff <= '0;
                           out_v_ff <= 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_HDR: begin
               count_ff <= '0;
               state_ff <= ST_PARSE;
            end
            ST_PARSE: begin
               if (!ok_c) state_ff <= ST_IDLE;
               else begin
                  pos_ff <= pos_c;
                  plen_ff <= n_ff - pos_c - 8'd2;
                  ptr_ff <= n_ff - 8'd2;
                  phase_ff <= 3'd0;
                  state_ff <= ST_SRCH;
                  arrival_ff <= arrival_ff + 8'd1;
               end
            end
            ST_SRCH: begin
               // phase 0..2: fetch check word; then find slot
               if (phase_ff == 3'd0) begin
                  ptr_ff <= n_ff - 8'd1;
                  phase_ff <= 3'd1;
               end else if (phase_ff == 3'd1) begin
                  pchk_ff[15:8] <= srd_ff;
                  phase_ff <= 3'd2;
               end else if (phase_ff == 3'd2) begin
                  pchk_ff[7:0] <= srd_ff;
                  idx_ff <= '0;
                  phase_ff <= 3'd3;
               end else if (rq_ff.consumed) state_ff <= ST_IDLE;
               else if (32'(idx_ff) >= TOTAL) state_ff <= ST_IDLE;
               else if (idx_small && 32'(plen_ff) >= SMALL_BYTES) begin
                  idx_ff <= SW'(SMALL_SLOTS);
               end else if (!idx_small && 32'(plen_ff) > LARGE_BYTES) begin
                  state_ff <= ST_IDLE;
               end else if (len_ff[idx_ff] != 7'd0) begin
                  idx_ff <= idx_n;
               end else begin
                  any_ff <= 1'b1;
                  tgt_ff <= idx_ff;
                  cur_small_ff <= idx_small;
                  len_ff[idx_ff] <= plen_ff[6:0];
                  seq_ff[idx_ff] <= hbx_ff[2];
                  hd_ff[idx_ff] <= (hbx_ff[1] & DEST_MODE_MASK) != 8'd0;
                  hs_ff[idx_ff] <= (hbx_ff[1] & SRC_MODE_MASK) != 8'd0;
                  dst_ff[idx_ff] <= dst_p;
                  src_ff[idx_ff] <= src_p;
                  chk_ff[idx_ff] <= pchk_ff;
                  energy_ff[idx_ff] <= rq_ff.energy_level;
                  stamp_ff[idx_ff] <= arrival_ff - 8'd1;
                  cp_ff <= '0;
                  ptr_ff <= pos_ff;
                  phase_ff <= 3'd0;
                  state_ff <= (plen_ff == 8'd0) ? ST_IDLE : ST_COPY;
               end
            end
            ST_COPY: begin
               ptr_ff <= ptr_ff + 8'd1;
               if (phase_ff != 3'd1) begin
                  phase_ff <= phase_ff + 3'd1;
               end else begin
                  cp_ff <= cp_ff + 8'd1;
                  if (cp_ff + 8'd1 == plen_ff) state_ff <= ST_IDLE;
               end
            end
            ST_FIND: begin
               cur_small_ff <= idx_small;
               if (32'(idx_ff) >= TOTAL) begin
                  out_ff <= '0;
                  out_v_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else if (len_ff[idx_ff] == 7'd0) begin
                  idx_ff <= idx_n;
               end else if (rq_ff.operation == OP_FIND_ANY) begin
                  state_ff <= ST_RSP;
               end else begin
                  state_ff <= ST_FWAIT;
               end
            end
            ST_FWAIT: begin
               if (rd_data == rq_ff.wanted_type) state_ff <= ST_RSP;
               else begin
                  idx_ff <= idx_n;
                  state_ff <= ST_FIND;
               end
            end
            ST_CLEAR: begin
               if (32'(idx_ff) >= TOTAL) begin
                  any_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  if (rq_ff.operation == OP_CLEAR_ALL || !idx_small || age_c > age_ff)
                     len_ff[idx_ff] <= '0;
                  idx_ff <= idx_n;
               end
            end
            ST_RWAIT: begin
               cur_small_ff <= idx_small;
               state_ff <= ST_RDATA;
            end
            ST_RDATA: begin
               out_ff <= slot_rsp(idx_ff, len_ff[idx_ff], seq_ff[idx_ff], hd_ff[idx_ff],
                                  dst_ff[idx_ff], hs_ff[idx_ff], src_ff[idx_ff],
                                  energy_ff[idx_ff], chk_ff[idx_ff], stamp_ff[idx_ff],
                                  rd_byte);
               out_v_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_RSP: begin
               out_ff <= slot_rsp(idx_ff, len_ff[idx_ff], seq_ff[idx_ff], hd_ff[idx_ff],
                                  dst_ff[idx_ff], hs_ff[idx_ff], src_ff[idx_ff],
                                  energy_ff[idx_ff], chk_ff[idx_ff], stamp_ff[idx_ff],
                                  8'd0);
               out_v_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

@@ bench/tb_rx_frame_parse_and_slot_store.sv @@
`timescale 1ns / 100ps

module tb_rx_frame_parse_and_slot_store;
   import rfp_pkg::*;

   localparam int SMALL_SLOTS = SMALL_SLOTS_DEF;
   localparam int SMALL_BYTES = SMALL_BYTES_DEF;
   localparam int LARGE_SLOTS = LARGE_SLOTS_DEF;
   localparam int LARGE_BYTES = LARGE_BYTES_DEF;
   localparam int TOTAL_SLOTS = SMALL_SLOTS + LARGE_SLOTS;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [7:0]  length;
      logic [7:0]  seq;
      logic        dst_present;
      logic        src_present;
      logic [7:0]  energy;
      logic [7:0]  arrival;
      logic [15:0] dest;
      logic [15:0] source;
      logic [15:0] check;
   } slot_rec_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rfp_req_if req_ch ();
   rfp_rsp_if rsp_ch ();
   rfp_csr_if csr_ch ();

   rx_frame_parse_and_slot_store uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [7:0] age_limit_m;
   logic [7:0] stage_buf [STAGE_DEPTH];
   int         stage_cnt;
   logic [7:0] arrival_cnt;
   logic       any_stored_m;
   slot_rec_t  slots_m [TOTAL_SLOTS];
   logic [7:0] small_pl [SMALL_SLOTS * SMALL_BYTES];
   logic [7:0] large_pl [LARGE_SLOTS * LARGE_BYTES];

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 21;
   int  recv_idle_pct = 45;
   int  hold_off_cycles = 0;

   logic       cfg_pending = 0;
   logic [7:0] cfg_value;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   function automatic logic [7:0] payload_byte(int s, int i);
      if (s < SMALL_SLOTS)
         return (i < SMALL_BYTES) ? small_pl[s * SMALL_BYTES + i] : 8'd0;
      if (s < TOTAL_SLOTS && i < LARGE_BYTES)
         return large_pl[(s - SMALL_SLOTS) * LARGE_BYTES + i];
      return 8'd0;
   endfunction

   function automatic rsp_type slot_result(int s);
      rsp_type r;
      r = '0;
      r.found = 1'b1;
      r.slot = s[3:0];
      r.payload_length = slots_m[s].length[6:0];
      r.frame_seq = slots_m[s].seq;
      r.dst_present = slots_m[s].dst_present;
      r.dst_short = slots_m[s].dst_present ? slots_m[s].dest : 16'd0;
      r.src_present = slots_m[s].src_present;
      r.src_short = slots_m[s].src_present ? slots_m[s].source : 16'd0;
      r.slot_energy = slots_m[s].energy;
      r.check_word = slots_m[s].check;
      r.arrival_seq = slots_m[s].arrival;
      return r;
   endfunction

   task automatic close_frame(input logic [7:0] energy, input logic consumed);
      int n, pos, len;
      slot_rec_t h;
      n = stage_cnt;
      pos = 3;
      stage_cnt = 0;
      if (n < 3)
         return;
      h = '{default: '0};
      h.seq = stage_buf[2];
      if ((stage_buf[1] & DEST_MODE_MASK) != 0) begin
         h.dst_present = 1'b1;
         if (pos + 4 > n)
            return;
         h.dest = {stage_buf[pos + 3], stage_buf[pos + 2]};
         pos += 4;
      end
      if ((stage_buf[1] & SRC_MODE_MASK) != 0) begin
         h.src_present = 1'b1;
         if (pos + 4 > n)
            return;
         h.source = {stage_buf[pos + 3], stage_buf[pos + 2]};
         pos += 4;
      end
      if (n < pos + 2)
         return;
      len = n - pos - 2;
      h.check = {stage_buf[n - 2], stage_buf[n - 1]};
      h.length = len[7:0];
      h.energy = energy;
      h.arrival = arrival_cnt;
      arrival_cnt++;
      if (consumed)
         return;
      if (len < SMALL_BYTES) begin
         for (int s = 0; s < SMALL_SLOTS; s++) begin
            if (slots_m[s].length == 0) begin
               for (int i = 0; i < len; i++)
                  small_pl[s * SMALL_BYTES + i] = stage_buf[pos + i];
               slots_m[s] = h;
               any_stored_m = 1'b1;
               return;
            end
         end
      end
      if (len > LARGE_BYTES)
         return;
      for (int s = 0; s < LARGE_SLOTS; s++) begin
         if (slots_m[SMALL_SLOTS + s].length == 0) begin
            for (int i = 0; i < len; i++)
               large_pl[s * LARGE_BYTES + i] = stage_buf[pos + i];
            slots_m[SMALL_SLOTS + s] = h;
            any_stored_m = 1'b1;
            return;
         end
      end
   endtask

   task automatic apply_request(input req_type q);
      rsp_type r;
      int s;
      logic [7:0] age;
      r = '0;
      case (q.operation)
         OP_BYTE: begin
            if (stage_cnt < STAGE_DEPTH) begin
               stage_buf[stage_cnt] = q.frame_byte;
               stage_cnt++;
            end
            if (q.frame_end)
               close_frame(q.energy_level, q.consumed);
         end
         OP_FIND_TYPE, OP_FIND_ANY: begin
            if (any_stored_m) begin
               for (s = 0; s < TOTAL_SLOTS; s++) begin
                  if (slots_m[s].length != 0 && (q.operation == OP_FIND_ANY ||
                      payload_byte(s, 0) == q.wanted_type)) begin
                     r = slot_result(s);
                     break;
                  end
               end
            end
            expected_rsps.push_back(r);
         end
         OP_CLEAR_ALL: begin
            if (any_stored_m) begin
               for (s = 0; s < TOTAL_SLOTS; s++)
                  slots_m[s].length = 0;
               any_stored_m = 1'b0;
            end
         end
         OP_CLEAR_OLD: begin
            if (any_stored_m) begin
               for (s = 0; s < SMALL_SLOTS; s++) begin
                  age = arrival_cnt - slots_m[s].arrival;
                  if (age > age_limit_m)
                     slots_m[s].length = 0;
               end
               for (s = SMALL_SLOTS; s < TOTAL_SLOTS; s++)
                  slots_m[s].length = 0;
               any_stored_m = 1'b0;
            end
         end
         OP_READ: begin
            s = q.slot_index;
            if (s < TOTAL_SLOTS && slots_m[s].length != 0) begin
               r = slot_result(s);
               if (q.byte_index < slots_m[s].length)
                  r.data_byte = payload_byte(s, q.byte_index);
            end
            expected_rsps.push_back(r);
         end
         default: ;
      endcase
   endtask

   // stimulus builders
   function automatic req_type rand_req();
      req_type q;
      q = '0;
      q.operation = 3'($urandom_range(0, 7));
      q.frame_byte = 8'($urandom);
      q.frame_end = 1'($urandom);
      q.energy_level = 8'($urandom);
      q.consumed = 1'($urandom);
      q.wanted_type = 8'($urandom);
      q.slot_index = 4'($urandom);
      q.byte_index = 7'($urandom);
      return q;
   endfunction

   task automatic push_op(input logic [2:0] op);
      req_type q;
      q = rand_req();
      q.operation = op;
      pending_reqs.push_back(q);
   endtask

   task automatic push_frame(input logic [7:0] ctl_hi, input int plen,
                             input int total, input logic consumed,
                             input logic [7:0] first_pl);
      req_type q;
      int hdr;
      hdr = 3 + (((ctl_hi & DEST_MODE_MASK) != 0) ? 4 : 0)
              + (((ctl_hi & SRC_MODE_MASK) != 0) ? 4 : 0);
      if (total < 0)
         total = hdr + plen + 2;
      for (int i = 0; i < total; i++) begin
         q = rand_req();
         q.operation = OP_BYTE;
         q.frame_end = (i == total - 1);
         q.consumed = consumed;
         if (i == 1)
            q.frame_byte = ctl_hi;
         else if (i == hdr)
            q.frame_byte = first_pl;
         pending_reqs.push_back(q);
      end
   endtask

   function automatic logic [7:0] rand_ctl();
      logic [7:0] c;
      c = 8'($urandom);
      if ($urandom_range(0, 1))
         c &= ~(DEST_MODE_MASK | SRC_MODE_MASK);
      return c;
   endfunction

   task automatic push_random_frame();
      int plen, pick;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         plen = $urandom_range(0, 4);
      else if (pick < 9)
         plen = $urandom_range(3, 20);
      else
         plen = $urandom_range(100, 117);
      push_frame(rand_ctl(), plen, -1, ($urandom_range(0, 5) == 0), 8'($urandom_range(0, 3)));
   endtask

   task automatic push_read();
      req_type q;
      q = rand_req();
      q.operation = OP_READ;
      q.slot_index = 4'($urandom_range(0, 15));
      q.byte_index = $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 3));
      pending_reqs.push_back(q);
   endtask

   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_age_limit(input logic [7:0] v);
      wait_quiet();
      cfg_value <= v;
      cfg_pending <= 1'b1;
      @(posedge clock);
      while (cfg_pending)
         @(posedge clock);
   endtask

   task automatic random_phase(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: push_random_frame();
            8:  push_frame(rand_ctl(), 0, $urandom_range(1, 8), 1'($urandom), 8'h00);
            9:  pending_reqs.push_back(rand_req());
            10, 11: push_op(OP_FIND_TYPE);
            12, 13: push_op(OP_FIND_ANY);
            14: push_op(($urandom_range(0, 3) == 0) ? OP_CLEAR_ALL : OP_CLEAR_OLD);
            default: push_read();
         endcase
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid)
            apply_request(req_ch.data);
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.data <= pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         csr_ch.valid <= 1'b0;
         csr_ch.data <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         age_limit_m = csr_ch.data;
         csr_ch.valid <= 1'b0;
         cfg_pending <= 1'b0;
      end else if (cfg_pending && !csr_ch.valid) begin
         csr_ch.data <= cfg_value;
         csr_ch.valid <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want, got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", 32'd0, 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.found !== want.found)
                  report_mismatch("found", 32'(got.found), 32'(want.found));
               if (got.slot !== want.slot)
                  report_mismatch("slot", 32'(got.slot), 32'(want.slot));
               if (got.payload_length !== want.payload_length)
                  report_mismatch("payload_length", 32'(got.payload_length),
                                  32'(want.payload_length));
               if (got.frame_seq !== want.frame_seq)
                  report_mismatch("frame_seq", 32'(got.frame_seq), 32'(want.frame_seq));
               if (got.dst_present !== want.dst_present)
                  report_mismatch("dst_present", 32'(got.dst_present),
                                  32'(want.dst_present));
               if (got.dst_short !== want.dst_short)
                  report_mismatch("dst_short", 32'(got.dst_short), 32'(want.dst_short));
               if (got.src_present !== want.src_present)
                  report_mismatch("src_present", 32'(got.src_present),
                                  32'(want.src_present));
               if (got.src_short !== want.src_short)
                  report_mismatch("src_short", 32'(got.src_short), 32'(want.src_short));
               if (got.slot_energy !== want.slot_energy)
                  report_mismatch("slot_energy", 32'(got.slot_energy), 32'(want.slot_energy));
               if (got.check_word !== want.check_word)
                  report_mismatch("check_word", 32'(got.check_word), 32'(want.check_word));
               if (got.arrival_seq !== want.arrival_seq)
                  report_mismatch("arrival_seq", 32'(got.arrival_seq), 32'(want.arrival_seq));
               if (got.data_byte !== want.data_byte)
                  report_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_rx_frame_parse_and_slot_store: done, errors");
         $finish;
      end
   end

   initial begin
      req_type q;
      age_limit_m = AGE_RESET;
      stage_cnt = 0;
      arrival_cnt = 0;
      any_stored_m = 1'b0;
      foreach (slots_m[s])
         slots_m[s] = '{default: '0};
      foreach (stage_buf[i])
         stage_buf[i] = '0;
      foreach (small_pl[i])
         small_pl[i] = '0;
      foreach (large_pl[i])
         large_pl[i] = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pool, all frame shapes, every operation
      push_op(OP_FIND_ANY);
      push_op(OP_FIND_TYPE);
      push_op(OP_CLEAR_ALL);
      push_op(OP_CLEAR_OLD);
      push_read();
      push_op(OP_RSVD_6);
      push_op(OP_RSVD_7);
      push_frame(8'h00, 0, 2, 1'b0, 8'h00);
      push_frame(8'hCC, 0, 9, 1'b0, 8'h00);
      push_frame(8'h00, 0, -1, 1'b0, 8'h00);
      push_frame(8'h0C, 1, -1, 1'b0, 8'hFF);
      push_frame(8'hC0, 2, -1, 1'b0, 8'h00);
      push_frame(8'hCC, 3, -1, 1'b0, 8'hA5);
      push_frame(8'h00, 2, -1, 1'b1, 8'h11);
      push_frame(8'h04, 127, -1, 1'b0, 8'h5A);
      push_frame(8'h00, 130, -1, 1'b0, 8'h22);
      q = rand_req();
      q.operation = OP_FIND_TYPE;
      q.wanted_type = 8'hA5;
      pending_reqs.push_back(q);
      push_op(OP_FIND_ANY);
      for (int s = 0; s < 13; s += 4) begin
         q = rand_req();
         q.operation = OP_READ;
         q.slot_index = s[3:0];
         q.byte_index = 7'd0;
         pending_reqs.push_back(q);
      end
      q.slot_index = 4'd15;
      q.byte_index = 7'h7F;
      pending_reqs.push_back(q);
      push_op(OP_CLEAR_OLD);
      push_op(OP_FIND_ANY);
      wait_quiet();

      write_age_limit(8'd0);
      random_phase(28);
      write_age_limit(8'd255);
      random_phase(28);

      // receiver stalls long while the sender keeps going
      hold_off_cycles <= 600;
      random_phase(25);
      wait_quiet();

      send_idle_pct = 45;
      recv_idle_pct = 21;
      write_age_limit(8'd1);
      random_phase(28);
      write_age_limit(8'($urandom));
      random_phase(28);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_age_limit(8'd3);
      random_phase(28);
      wait_quiet();

      if (error_count == 0)
         $display("tb_rx_frame_parse_and_slot_store: done, clean");
      else
         $display("tb_rx_frame_parse_and_slot_store: done, errors");
      $finish;
   end
endmodule
